[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the lowest-common-ancestor block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that expr holds in every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`endif

`endif

[rtl/blca_pkg.sv]
// Package for the binary-lifting lowest-common-ancestor block.
// Holds field widths, item codes, sequencer states and the shared unit's op codes.
`timescale 1ns / 1ps

package blca_pkg;

    // Field widths of the stream items
    localparam int NODE_W    = 10;
    localparam int DEPTH_W   = 10;
    localparam int DIST_W    = 11;
    localparam int ALU_W     = DEPTH_W + 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Depth saturates here
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Item kinds carried on s_tuser
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Shared add/subtract unit operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_RD_DEP,
        ST_A_WR0,
        ST_A_RD,
        ST_A_WR,
        ST_Q_RD_DA,
        ST_Q_RD_DB,
        ST_Q_SWAP,
        ST_Q_LIFT,
        ST_Q_LIFT_X,
        ST_Q_LIFT_D,
        ST_Q_EQ,
        ST_Q_UP,
        ST_Q_UP_X,
        ST_Q_UP_Y,
        ST_Q_PAR,
        ST_Q_PAR_D,
        ST_Q_DL,
        ST_Q_SUM,
        ST_Q_DIST
    } state_t;

endpackage

[rtl/blca_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic storage used for the ancestor and depth tables; no package needed.
`timescale 1ns / 1ps

module blca_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/blca_alu.sv]
// Shared add/subtract unit of the lowest-common-ancestor sequencer.
// Depends on blca_pkg for the operand width and op codes.
`timescale 1ns / 1ps

module blca_alu (
    input  blca_pkg::alu_op_t               op,
    input  logic [blca_pkg::ALU_W-1:0]      op_a,
    input  logic [blca_pkg::ALU_W-1:0]      op_b,
    output logic [blca_pkg::ALU_W-1:0]      res
);

    import blca_pkg::*;

    // Top bit of a subtract result is the borrow
    always_comb begin
        unique case (op)
            ALU_ADD: res = op_a + op_b;
            ALU_SUB: res = op_a - op_b;
        endcase
    end

endmodule

[rtl/blca_seq.sv]
// Sequencer and datapath of the lowest-common-ancestor block: walks the tables
// one memory read at a time through the shared unit. Depends on blca_pkg,
// blca_alu and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blca_seq #(
    parameter int NODE_COUNT  = 1024,
    parameter int LIFT_LEVELS = 11
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // input items
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic                                          s_mode,
    input  logic [blca_pkg::NODE_W-1:0]                   s_node_a,
    input  logic [blca_pkg::NODE_W-1:0]                   s_node_b,
    // result items
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [blca_pkg::NODE_W-1:0]                   m_ancestor,
    output logic [blca_pkg::DIST_W-1:0]                   m_distance,
    // ancestor table
    output logic                                          anc_wr_en,
    output logic [$clog2(NODE_COUNT*LIFT_LEVELS)-1:0]     anc_wr_addr,
    output logic [blca_pkg::NODE_W-1:0]                   anc_wr_data,
    output logic [$clog2(NODE_COUNT*LIFT_LEVELS)-1:0]     anc_rd_addr,
    input  logic [blca_pkg::NODE_W-1:0]                   anc_rd_data,
    // depth table
    output logic                                          dep_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0]                 dep_wr_addr,
    output logic [blca_pkg::DEPTH_W-1:0]                  dep_wr_data,
    output logic [$clog2(NODE_COUNT)-1:0]                 dep_rd_addr,
    input  logic [blca_pkg::DEPTH_W-1:0]                  dep_rd_data
);

    import blca_pkg::*;

    localparam int AAW = $clog2(NODE_COUNT * LIFT_LEVELS);
    localparam int NAW = $clog2(NODE_COUNT);
    localparam int LW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int SW  = (LIFT_LEVELS > DEPTH_W) ? LIFT_LEVELS : DEPTH_W;
    localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);

    state_t               state_reg, state_next;
    logic [NODE_W-1:0]    x_reg, x_next;
    logic [NODE_W-1:0]    y_reg, y_next;
    logic [NODE_W-1:0]    ax_reg, ax_next;
    logic [NODE_W-1:0]    l_reg, l_next;
    logic [DEPTH_W-1:0]   dx_reg, dx_next;
    logic [DEPTH_W-1:0]   dy_reg, dy_next;
    logic [DEPTH_W-1:0]   da0_reg, da0_next;
    logic [DEPTH_W-1:0]   db0_reg, db0_next;
    logic [DEPTH_W-1:0]   dl_reg, dl_next;
    logic [DEPTH_W:0]     sum_reg, sum_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]    out_anc_reg, out_anc_next;
    logic [DIST_W-1:0]    out_dist_reg, out_dist_next;
    logic                 anc_zero_reg;
    logic                 dep_zero_reg;

    logic [NODE_W-1:0]    anc_rd_node;
    logic [LW-1:0]        anc_rd_lvl;
    logic [LW-1:0]        anc_wr_lvl;
    logic [NODE_W-1:0]    dep_rd_node;
    logic [NODE_W-1:0]    anc_val;
    logic [DEPTH_W-1:0]   dep_val;
    logic [DEPTH_W-1:0]   dep_sat;
    logic                 accept;
    logic                 lift_ok;
    logic [SW-1:0]        step_w;
    logic                 out_free;

    alu_op_t              alu_op;
    logic [ALU_W-1:0]     alu_a;
    logic [ALU_W-1:0]     alu_b;
    logic [ALU_W-1:0]     alu_res;

    // Node numbers at or above NODE_COUNT act as the sentinel root
    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return (32'(n) < 32'(NODE_COUNT));
    endfunction

    // Ancestor table is laid out level by level
    function automatic logic [AAW-1:0] anc_addr(input logic [NODE_W-1:0] n,
                                                 input logic [LW-1:0]     l);
        return AAW'(l) * AAW'(NODE_COUNT) + AAW'(n);
    endfunction

    blca_alu u_alu (
        .op   (alu_op),
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    // Node zero reads as depth zero with every ancestor zero
    assign anc_val = anc_zero_reg ? '0 : anc_rd_data;
    assign dep_val = dep_zero_reg ? '0 : dep_rd_data;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;

    // Lift x while depth(x) - depth(y) is at least 2^lvl
    assign step_w  = SW'(1) << lvl_reg;
    assign lift_ok = !alu_res[ALU_W-1] && (SW'(alu_res[DEPTH_W-1:0]) >= step_w);

    // Parent depth plus one, saturated
    assign dep_sat = (alu_res[ALU_W-1:DEPTH_W] != '0) ? DEPTH_MAX : alu_res[DEPTH_W-1:0];

    // Memory ports
    assign anc_rd_addr = anc_addr(anc_rd_node, anc_rd_lvl);
    assign anc_wr_addr = anc_addr(x_reg, anc_wr_lvl);
    assign anc_wr_data = (state_reg == ST_A_WR0) ? y_reg : anc_val;
    assign anc_wr_en   = (state_reg == ST_A_WR0) || (state_reg == ST_A_WR);
    assign anc_wr_lvl  = (state_reg == ST_A_WR0) ? '0 : lvl_reg;
    assign dep_rd_addr = NAW'(dep_rd_node);
    assign dep_wr_addr = NAW'(x_reg);
    assign dep_wr_data = dep_sat;
    assign dep_wr_en   = (state_reg == ST_A_WR0);

    assign m_valid    = out_valid_reg;
    assign m_ancestor = out_anc_reg;
    assign m_distance = out_dist_reg;

    // Read address and shared unit selection
    always_comb begin
        anc_rd_node = x_reg;
        anc_rd_lvl  = lvl_reg;
        dep_rd_node = x_reg;
        alu_op      = ALU_SUB;
        alu_a       = ALU_W'(dx_reg);
        alu_b       = ALU_W'(dy_reg);
        unique case (state_reg)
            ST_A_RD_DEP: dep_rd_node = y_reg;
            ST_A_WR0: begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(dep_val);
                alu_b  = ALU_W'(1);
            end
            ST_A_RD: begin
                anc_rd_node = y_reg;
                anc_rd_lvl  = lvl_reg - LW'(1);
            end
            ST_Q_RD_DB:  dep_rd_node = y_reg;
            ST_Q_SWAP: begin
                alu_a = ALU_W'(da0_reg);
                alu_b = ALU_W'(dep_val);
            end
            ST_Q_LIFT_X: dep_rd_node = anc_val;
            ST_Q_UP_X:   anc_rd_node = y_reg;
            ST_Q_PAR:    anc_rd_lvl  = '0;
            ST_Q_DL:     dep_rd_node = l_reg;
            ST_Q_SUM: begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(da0_reg);
                alu_b  = ALU_W'(db0_reg);
            end
            ST_Q_DIST: begin
                alu_a = ALU_W'(sum_reg);
                alu_b = ALU_W'({dl_reg, 1'b0});
            end
            default: begin
            end
        endcase
    end

    // Next state and datapath updates
    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ax_next        = ax_reg;
        l_next         = l_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        da0_next       = da0_reg;
        db0_next       = db0_reg;
        dl_next        = dl_reg;
        sum_next       = sum_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_anc_next   = out_anc_reg;
        out_dist_next  = out_dist_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    y_next = node_ok(s_node_b) ? s_node_b : '0;
                    if (s_mode == MODE_QUERY) begin
                        x_next     = node_ok(s_node_a) ? s_node_a : '0;
                        state_next = ST_Q_RD_DA;
                    end else begin
                        // drop adds of the sentinel or of an unknown node
                        x_next = s_node_a;
                        if ((s_node_a != '0) && node_ok(s_node_a)) begin
                            state_next = ST_A_RD_DEP;
                        end
                    end
                end
            end

            // Add: depth and first level, then one level per read
            ST_A_RD_DEP: state_next = ST_A_WR0;
            ST_A_WR0: begin
                lvl_next   = LW'(1);
                state_next = (LIFT_LEVELS > 1) ? ST_A_RD : ST_IDLE;
            end
            ST_A_RD: state_next = ST_A_WR;
            ST_A_WR: begin
                y_next = anc_val;
                if (lvl_reg == LVL_TOP) begin
                    state_next = ST_IDLE;
                end else begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = ST_A_RD;
                end
            end

            // Query: fetch both depths, put the deeper node in x
            ST_Q_RD_DA: state_next = ST_Q_RD_DB;
            ST_Q_RD_DB: begin
                da0_next   = dep_val;
                state_next = ST_Q_SWAP;
            end
            ST_Q_SWAP: begin
                db0_next = dep_val;
                lvl_next = LVL_TOP;
                if (alu_res[ALU_W-1]) begin
                    x_next  = y_reg;
                    y_next  = x_reg;
                    dx_next = dep_val;
                    dy_next = da0_reg;
                end else begin
                    dx_next = da0_reg;
                    dy_next = dep_val;
                end
                state_next = ST_Q_LIFT;
            end

            // Raise x to the depth of y
            ST_Q_LIFT: begin
                if (lift_ok) begin
                    state_next = ST_Q_LIFT_X;
                end else if (lvl_reg == '0) begin
                    state_next = ST_Q_EQ;
                end else begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            ST_Q_LIFT_X: begin
                x_next     = anc_val;
                state_next = ST_Q_LIFT_D;
            end
            ST_Q_LIFT_D: begin
                dx_next = dep_val;
                if (lvl_reg == '0) begin
                    state_next = ST_Q_EQ;
                end else begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ST_Q_LIFT;
                end
            end

            ST_Q_EQ: begin
                if (x_reg == y_reg) begin
                    l_next     = x_reg;
                    state_next = ST_Q_DL;
                end else begin
                    lvl_next   = LVL_TOP;
                    state_next = ST_Q_UP;
                end
            end

            // Raise both nodes while their ancestors differ
            ST_Q_UP:   state_next = ST_Q_UP_X;
            ST_Q_UP_X: begin
                ax_next    = anc_val;
                state_next = ST_Q_UP_Y;
            end
            ST_Q_UP_Y: begin
                if (ax_reg != anc_val) begin
                    x_next = ax_reg;
                    y_next = anc_val;
                end
                if (lvl_reg == '0) begin
                    state_next = ST_Q_PAR;
                end else begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ST_Q_UP;
                end
            end
            ST_Q_PAR:   state_next = ST_Q_PAR_D;
            ST_Q_PAR_D: begin
                l_next     = anc_val;
                state_next = ST_Q_DL;
            end

            // Distance: depth(a) + depth(b) - 2 * depth(lca), floored at zero
            ST_Q_DL:  state_next = ST_Q_SUM;
            ST_Q_SUM: begin
                dl_next    = dep_val;
                sum_next   = alu_res[DEPTH_W:0];
                state_next = ST_Q_DIST;
            end
            ST_Q_DIST: begin
                // hold until the output register is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_anc_next   = l_reg;
                    out_dist_next  = alu_res[ALU_W-1] ? '0 : alu_res[DIST_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        ax_reg       <= ax_next;
        l_reg        <= l_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        da0_reg      <= da0_next;
        db0_reg      <= db0_next;
        dl_reg       <= dl_next;
        sum_reg      <= sum_next;
        out_anc_reg  <= out_anc_next;
        out_dist_reg <= out_dist_next;
        anc_zero_reg <= (anc_rd_node == '0);
        dep_zero_reg <= (dep_rd_node == '0);
    end

    `ASSERT_ALWAYS(a_lvl_bound, aclk, aresetn, lvl_reg <= LVL_TOP, "level counter out of range")
    `ASSERT_IMPLIES(a_wr_not_root, aclk, aresetn, anc_wr_en, x_reg != '0, "write to sentinel node")
    `ASSERT_IMPLIES(a_dep_nonzero, aclk, aresetn, dep_wr_en, dep_wr_data != '0, "added node at depth zero")
    `ASSERT_NEXT(a_query_busy, aclk, aresetn, accept && (s_mode == MODE_QUERY), !s_ready, "query item did not start a walk")
    `ASSERT_IMPLIES(a_load_end, aclk, aresetn, $rose(out_valid_reg), $past(state_reg == ST_Q_DIST), "result loaded outside the last query step")

endmodule

[rtl/binary_lifting_lca.sv]
// Lowest common ancestor by binary lifting, with a stream input and a stream
// result channel. An add item (s_tuser = 0) does one depth read and writes the
// depth and the first ancestor level, then reads and writes each further level
// over the single read port of the ancestor table, each level read only after
// the one below is written. A query item (s_tuser = 1) does two depth reads, a
// lift pass over the levels and, unless the lift already lands on the other
// node, an ascend pass and a parent read, all through the single ancestor and
// depth read ports and one shared add/subtract unit, then the distance. One
// item is in work at a time; the result waits in an output register while the
// next item is accepted. The tables are not cleared: node 0 is served as the
// sentinel root by logic, and a node must be added before it is used as a
// parent or queried.
// Depends on blca_pkg, blca_ram and blca_seq.
`timescale 1ns / 1ps

module binary_lifting_lca #(
    parameter int NODE_COUNT  = 1024,
    parameter int LIFT_LEVELS = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [blca_pkg::S_TDATA_W-1:0]    s_tdata,   // node_a[9:0], node_b[19:10]
    input  logic [0:0]                        s_tuser,   // mode[0]
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [blca_pkg::M_TDATA_W-1:0]    m_tdata    // ancestor[9:0], distance[20:10]
);

    import blca_pkg::*;

    localparam int ANC_DEPTH = NODE_COUNT * LIFT_LEVELS;
    localparam int AAW       = $clog2(ANC_DEPTH);
    localparam int NAW       = $clog2(NODE_COUNT);
    localparam int PAD_W     = M_TDATA_W - NODE_W - DIST_W;

    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [NODE_W-1:0]  ancestor;
    logic [DIST_W-1:0]  distance;

    logic               anc_wr_en;
    logic [AAW-1:0]     anc_wr_addr;
    logic [NODE_W-1:0]  anc_wr_data;
    logic [AAW-1:0]     anc_rd_addr;
    logic [NODE_W-1:0]  anc_rd_data;
    logic               dep_wr_en;
    logic [NAW-1:0]     dep_wr_addr;
    logic [DEPTH_W-1:0] dep_wr_data;
    logic [NAW-1:0]     dep_rd_addr;
    logic [DEPTH_W-1:0] dep_rd_data;

    // Unpack input fields, pack result fields
    assign node_a  = s_tdata[NODE_W-1:0];
    assign node_b  = s_tdata[2*NODE_W-1:NODE_W];
    assign m_tdata = {{PAD_W{1'b0}}, distance, ancestor};

    blca_seq #(
        .NODE_COUNT  (NODE_COUNT),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_mode      (s_tuser[0]),
        .s_node_a    (node_a),
        .s_node_b    (node_b),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_ancestor  (ancestor),
        .m_distance  (distance),
        .anc_wr_en   (anc_wr_en),
        .anc_wr_addr (anc_wr_addr),
        .anc_wr_data (anc_wr_data),
        .anc_rd_addr (anc_rd_addr),
        .anc_rd_data (anc_rd_data),
        .dep_wr_en   (dep_wr_en),
        .dep_wr_addr (dep_wr_addr),
        .dep_wr_data (dep_wr_data),
        .dep_rd_addr (dep_rd_addr),
        .dep_rd_data (dep_rd_data)
    );

    // Ancestor table, one row of nodes per lifting level
    blca_ram #(
        .DEPTH (ANC_DEPTH),
        .WIDTH (NODE_W)
    ) u_anc_ram (
        .aclk    (aclk),
        .wr_en   (anc_wr_en),
        .wr_addr (anc_wr_addr),
        .wr_data (anc_wr_data),
        .rd_addr (anc_rd_addr),
        .rd_data (anc_rd_data)
    );

    // Depth table
    blca_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (DEPTH_W)
    ) u_dep_ram (
        .aclk    (aclk),
        .wr_en   (dep_wr_en),
        .wr_addr (dep_wr_addr),
        .wr_data (dep_wr_data),
        .rd_addr (dep_rd_addr),
        .rd_data (dep_rd_data)
    );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for binary_lifting_lca: builds trees, queries them, checks each result.
// A clocked driver sends queued add and query items, and a clocked monitor checks each result.
// Depends on blca_pkg and the binary_lifting_lca RTL.
`timescale 1ns / 1ps

module tb_top;

    import blca_pkg::*;

    localparam int NODE_COUNT   = 1024;
    localparam int LIFT_LEVELS  = 11;
    localparam int RANDOM_ITEMS = 450;
    localparam int RAMP_ADDS    = 256;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [DIST_W-1:0]  dist_t;

    localparam node_t ROOT_NODE = '0;
    localparam node_t TOP_NODE  = node_t'(NODE_COUNT - 1);

    typedef struct packed {
        logic  mode;
        node_t node_a;
        node_t node_b;
    } lca_req_t;

    typedef struct packed {
        node_t node_a;
        node_t node_b;
        node_t ancestor;
        dist_t distance;
    } lca_res_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted tree state: depth and power-of-two ancestors per node
    depth_t lift_depth [NODE_COUNT];
    node_t  lift_up    [NODE_COUNT][LIFT_LEVELS];

    lca_req_t pending_q[$];
    lca_res_t lca_expect_q[$];

    // Stimulus-side view of which nodes exist
    bit    gen_present [NODE_COUNT];
    node_t added_q[$];
    int    free_cnt = NODE_COUNT - 1;

    lca_req_t cur_req;
    int       accepted_cnt = 0;
    int       total_items  = 0;
    int       err_count    = 0;
    int       cycle_cnt    = 0;
    int       hold_left    = 0;
    int       hold_idx     = 0;
    int       send_gap     = 0;
    int       send_stretch = 0;
    bit       send_quiet   = 1'b0;
    int       recv_gap     = 0;
    int       recv_stretch = 0;
    bit       recv_quiet   = 1'b0;

    binary_lifting_lca #(
        .NODE_COUNT  (NODE_COUNT),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // node_a[9:0], node_b[19:10]
        .s_tuser  (s_tuser),   // mode[0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // ancestor[9:0], distance[20:10]
    );

    always #1 aclk = ~aclk;

    // Lift the deeper node to the other's depth, then lift both while they differ
    function automatic node_t common_ancestor(node_t x, node_t y);
        node_t t;
        if (lift_depth[x] < lift_depth[y]) begin
            t = x;
            x = y;
            y = t;
        end
        for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
            if (int'(lift_depth[x]) >= int'(lift_depth[y]) + (1 << lvl))
                x = lift_up[x][lvl];
        end
        if (x == y)
            return x;
        for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
            if (lift_up[x][lvl] != lift_up[y][lvl]) begin
                x = lift_up[x][lvl];
                y = lift_up[y][lvl];
            end
        end
        return lift_up[x][0];
    endfunction

    // Update the tree for an add, or queue the answer of a query.
    // Node numbers are 10 bits wide, so none is ever out of range here.
    function automatic void apply_item(lca_req_t r);
        int       d;
        node_t    anc;
        lca_res_t res;
        if (r.mode == MODE_ADD) begin
            // The sentinel root stays fixed
            if (r.node_a == ROOT_NODE)
                return;
            d = int'(lift_depth[r.node_b]) + 1;
            if (d > int'(DEPTH_MAX))
                d = int'(DEPTH_MAX);
            lift_depth[r.node_a] = depth_t'(d);
            lift_up[r.node_a][0] = r.node_b;
            for (int lvl = 1; lvl < LIFT_LEVELS; lvl++)
                lift_up[r.node_a][lvl] = lift_up[lift_up[r.node_a][lvl-1]][lvl-1];
        end else begin
            anc = common_ancestor(r.node_a, r.node_b);
            d = int'(lift_depth[r.node_a]) + int'(lift_depth[r.node_b])
                - 2 * int'(lift_depth[anc]);
            // A broken tree can give a negative path length
            if (d < 0)
                d = 0;
            res.node_a   = r.node_a;
            res.node_b   = r.node_b;
            res.ancestor = anc;
            res.distance = dist_t'(d);
            lca_expect_q.insert(lca_expect_q.size(), res);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Mostly short gaps, a few long ones, with stretches of no gaps at all
    task automatic next_gap(inout int stretch, inout bit quiet, output int gap);
        int r;
        if (stretch == 0) begin
            quiet   = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(20, 80);
        end
        stretch--;
        r = $urandom_range(0, 99);
        if (quiet || r < 45)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
    endtask

    task automatic mark_added(node_t n);
        if (n != ROOT_NODE && !gen_present[n]) begin
            gen_present[n] = 1'b1;
            added_q.insert(added_q.size(), n);
            free_cnt--;
        end
    endtask

    task automatic push_add(node_t a, node_t b);
        lca_req_t r;
        r.mode   = MODE_ADD;
        r.node_a = a;
        r.node_b = b;
        pending_q.insert(pending_q.size(), r);
        mark_added(a);
    endtask

    task automatic push_query(node_t a, node_t b);
        lca_req_t r;
        r.mode   = MODE_QUERY;
        r.node_a = a;
        r.node_b = b;
        pending_q.insert(pending_q.size(), r);
    endtask

    // Pick a node already in the tree, or now and then the root
    function automatic node_t pick_node(bit allow_root);
        if (allow_root && $urandom_range(0, 9) == 0)
            return ROOT_NODE;
        return added_q[$urandom_range(0, added_q.size() - 1)];
    endfunction

    function automatic node_t pick_fresh();
        node_t n;
        n = node_t'($urandom_range(1, NODE_COUNT - 1));
        while (gen_present[n])
            n = node_t'($urandom_range(1, NODE_COUNT - 1));
        return n;
    endfunction

    // Send queued items, advance the prediction on each accepted one
    always @(posedge aclk) begin : feed_proc
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(cur_req);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    cur_req = pending_q.pop_front();
                    s_tdata  <= {{(S_TDATA_W - 2*NODE_W){1'b0}}, cur_req.node_b, cur_req.node_a};
                    s_tuser  <= cur_req.mode;
                    s_tvalid <= 1'b1;
                    next_gap(send_stretch, send_quiet, send_gap);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold off the result side twice for a long stretch so the block backs up
    always @(posedge aclk) begin : hold_proc
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_idx < 2 && accepted_cnt >= (hold_idx == 0 ? 40 : 400)) begin
            hold_left <= HOLD_CYCLES;
            hold_idx  <= hold_idx + 1;
        end
    end

    // Check each result against the oldest pending answer, then pace m_tready
    always @(posedge aclk) begin : sink_proc
        lca_res_t want;
        node_t    got_anc;
        dist_t    got_dist;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_anc  = m_tdata[NODE_W-1:0];
                got_dist = m_tdata[NODE_W +: DIST_W];
                if (lca_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result ancestor=%0d distance=%0d with no query pending",
                                              got_anc, got_dist));
                end else begin
                    want = lca_expect_q.pop_front();
                    if (got_anc !== want.ancestor)
                        report_mismatch($sformatf("query (%0d,%0d): ancestor %0d, want %0d",
                                                  want.node_a, want.node_b, got_anc, want.ancestor));
                    if (got_dist !== want.distance)
                        report_mismatch($sformatf("query (%0d,%0d): distance %0d, want %0d",
                                                  want.node_a, want.node_b, got_dist, want.distance));
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    next_gap(recv_stretch, recv_quiet, recv_gap);
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge aclk) begin : limit_proc
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : run_ctl
        int    rand_cnt;
        int    sel;
        int    len;
        node_t par;
        node_t kid;

        // Node 0 is the sentinel: depth 0, every ancestor 0
        for (int n = 0; n < NODE_COUNT; n++) begin
            lift_depth[n] = '0;
            for (int lvl = 0; lvl < LIFT_LEVELS; lvl++)
                lift_up[n][lvl] = '0;
        end

        // Directed: root-only query, extreme node numbers, ignored add of the root,
        // re-add under a deeper node, and a re-add under its own child
        push_query(ROOT_NODE, ROOT_NODE);
        push_add(10'd1, ROOT_NODE);
        push_add(TOP_NODE, 10'd1);
        push_add(10'd512, TOP_NODE);
        push_add(10'd2, 10'd1);
        push_add(ROOT_NODE, 10'd1);
        push_query(TOP_NODE, 10'd2);
        push_query(10'd2, TOP_NODE);
        push_query(10'd512, 10'd512);
        push_query(ROOT_NODE, 10'd512);
        push_query(10'd512, ROOT_NODE);
        push_query(TOP_NODE, 10'd512);
        push_add(10'd3, 10'd2);
        push_query(10'd3, 10'd512);
        push_add(10'd2, 10'd512);
        push_query(10'd2, TOP_NODE);
        push_query(10'd3, 10'd2);
        push_add(TOP_NODE, 10'd512);
        push_query(TOP_NODE, 10'd2);
        push_query(10'd512, 10'd3);
        push_query(10'd1, TOP_NODE);

        // Random: mostly chains of new nodes and queries, some re-adds and ignored adds
        rand_cnt = 0;
        while (rand_cnt < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                par = pick_node(1'b1);
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    kid = (free_cnt > 0 && $urandom_range(0, 9) != 0) ? pick_fresh()
                                                                       : pick_node(1'b0);
                    push_add(kid, par);
                    par = kid;
                    rand_cnt++;
                end
            end else if (sel < 90) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    push_query(pick_node(1'b1), pick_node(1'b1));
                    rand_cnt++;
                end
            end else if (sel < 96) begin
                push_add(pick_node(1'b0), pick_node(1'b1));
                rand_cnt++;
            end else begin
                push_add(ROOT_NODE, node_t'($urandom_range(0, NODE_COUNT - 1)));
            end
        end

        // Deepen one node under itself, probing on the way
        for (int i = 0; i < RAMP_ADDS; i++) begin
            push_add(TOP_NODE, TOP_NODE);
            if (i % 128 == 127) begin
                push_query(TOP_NODE, pick_node(1'b1));
                push_query(pick_node(1'b1), TOP_NODE);
                push_query(TOP_NODE, ROOT_NODE);
            end
        end
        total_items = pending_q.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != total_items)
            @(posedge aclk);
        while (lca_expect_q.size() != 0)
            @(posedge aclk);
        // Let a trailing add finish and catch any stray result
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[binary_lifting_lca.f]
+incdir+rtl
rtl/blca_pkg.sv
rtl/blca_ram.sv
rtl/blca_alu.sv
rtl/blca_seq.sv
rtl/binary_lifting_lca.sv
dv/tb_top.sv
